// ----- hdl/fbrt_pkg.sv -----
package fbrt_pkg;

  // field widths of the request and response
  localparam int ACTION_W  = 2;
  localparam int LOGICAL_W = 12;
  localparam int ENTRY_W   = 12;
  localparam int STATE_W   = 2;
  localparam int STATUS_W  = 2;
  localparam int PHYS_W    = 12;
  localparam int ADDR_W    = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int BLOCKS_W   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_BASE    = 1'd1;

  localparam logic [BLOCKS_W-1:0] RESET_BLOCKS = 13'd3968;

  // parameter defaults
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int BLOCK_BYTES_DEF   = 256;

  // actions
  localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTORE = 2'd2;

  // block states
  localparam logic [STATE_W-1:0] ST_UNUSED = 2'd0;
  localparam logic [STATE_W-1:0] ST_VALID  = 2'd1;
  localparam logic [STATE_W-1:0] ST_DIRTY  = 2'd2;
  localparam logic [STATE_W-1:0] ST_FREE   = 2'd3;

  // response status
  localparam logic [STATUS_W-1:0] RC_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] RC_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] RC_UNMAPPED = 2'd2;
  localparam logic [STATUS_W-1:0] RC_FULL     = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [LOGICAL_W-1:0] logical_index;
    logic [ENTRY_W-1:0]   entry_index;
    logic [STATE_W-1:0]   entry_state;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PHYS_W-1:0]   physical_index;
    logic [ADDR_W-1:0]   physical_address;
    logic                old_retired;
  } rsp_t;

  // one table entry
  typedef struct packed {
    logic [STATE_W-1:0]   st;
    logic [LOGICAL_W-1:0] lg;
  } entry_t;

endpackage

// ----- hdl/flash_block_remap_table.sv -----
// channel   ports                                  handshake
// -------   -------------------------------------  ---------------------------------
// request   start, busy, in_req                    taken when start && !busy
// response  out_valid, out_rsp                     one-cycle strobe, cannot be held
// config    cfg_valid, cfg_ready, cfg_index,       written when cfg_valid && cfg_ready
//           cfg_data                               (cfg_ready is always high)
//
// lookups and writes scan the managed table through the one read port, an entry a cycle;
// a write adds a table write, a retire adds one more; restores skip the scan and rejected
// requests skip the scan and writes; the strobe is in the first cycle with busy low
// after reset a clearing pass writes every entry free, with busy high;
// configuration writes are taken in every state and the strobe is never stalled
module flash_block_remap_table #(
  parameter int TABLE_ENTRIES = fbrt_pkg::TABLE_ENTRIES_DEF,
  parameter int BLOCK_BYTES   = fbrt_pkg::BLOCK_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  fbrt_pkg::req_t                    in_req,
  // response channel
  output logic                              out_valid,
  output fbrt_pkg::rsp_t                    out_rsp,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbrt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WR_OLD,
    S_WR_NEW,
    S_MUL,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [fbrt_pkg::BLOCKS_W-1:0]   blocks_r;
  logic [fbrt_pkg::ADDR_W-1:0]     base_r;

  // request context
  fbrt_pkg::req_t                  req_r;
  logic [CNT_W-1:0]                n_r;       // managed count at accept
  logic [CNT_W-1:0]                scan_r;    // read address, also clear counter
  logic                            rd_vld_r;
  logic [CNT_W-1:0]                rd_idx_r;
  logic                            hit_f_r;
  logic [IDX_W-1:0]                hit_r;
  logic                            free_f_r;
  logic [IDX_W-1:0]                free_r;
  logic [IDX_W-1:0]                idx_r;
  fbrt_pkg::entry_t                wdata_r;
  logic [fbrt_pkg::STATUS_W-1:0]   status_r;
  logic                            retired_r;
  logic [fbrt_pkg::ADDR_W-1:0]     prod_r;

  // output registers
  logic                            out_valid_r;
  fbrt_pkg::rsp_t                  out_rsp_r;

  // table memory
  fbrt_pkg::entry_t                mem [TABLE_ENTRIES];
  fbrt_pkg::entry_t                rd_data_r;
  logic                            mem_we;
  logic [IDX_W-1:0]                mem_wa;
  fbrt_pkg::entry_t                mem_wd;

  // effective block count, limited to the table size
  logic [fbrt_pkg::BLOCKS_W-1:0]   n_eff;
  logic                            lg_ok;
  logic                            ent_ok;

  assign n_eff  = (blocks_r > fbrt_pkg::BLOCKS_W'(TABLE_ENTRIES))
                  ? fbrt_pkg::BLOCKS_W'(TABLE_ENTRIES) : blocks_r;
  assign lg_ok  = fbrt_pkg::BLOCKS_W'(in_req.logical_index) < n_eff;
  assign ent_ok = fbrt_pkg::BLOCKS_W'(in_req.entry_index) < n_eff;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // memory write port: clearing pass, retire of old mapping, new or restored entry
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = wdata_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = scan_r[IDX_W-1:0];
        mem_wd = '{st: fbrt_pkg::ST_FREE, lg: '0};
      end
      S_WR_OLD: begin
        mem_we = 1'b1;
        mem_wa = hit_r;
        mem_wd = '{st: fbrt_pkg::ST_DIRTY, lg: req_r.logical_index};
      end
      S_WR_NEW: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[scan_r[IDX_W-1:0]];
  end

  // configuration writes, taken in any state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r <= fbrt_pkg::RESET_BLOCKS;
      base_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbrt_pkg::REG_BLOCKS_IN_USE: blocks_r <= cfg_data[fbrt_pkg::BLOCKS_W-1:0];
        fbrt_pkg::REG_FLASH_BASE:    base_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (scan_r == CNT_W'(TABLE_ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
          scan_r <= scan_r + CNT_W'(1);
        end

        S_IDLE: begin
          if (start) begin
            req_r     <= in_req;
            n_r       <= CNT_W'(n_eff);
            scan_r    <= '0;
            rd_vld_r  <= 1'b0;
            hit_f_r   <= 1'b0;
            free_f_r  <= 1'b0;
            retired_r <= 1'b0;
            idx_r     <= '0;
            status_r  <= fbrt_pkg::RC_RANGE;
            case (in_req.action)
              fbrt_pkg::ACT_LOOKUP,
              fbrt_pkg::ACT_WRITE: begin
                state_r <= lg_ok ? S_SCAN : S_MUL;
              end
              fbrt_pkg::ACT_RESTORE: begin
                if (ent_ok && (in_req.entry_state == fbrt_pkg::ST_FREE || lg_ok)) begin
                  idx_r      <= in_req.entry_index[IDX_W-1:0];
                  wdata_r.st <= in_req.entry_state;
                  wdata_r.lg <= (in_req.entry_state == fbrt_pkg::ST_FREE)
                                ? '0 : in_req.logical_index;
                  status_r   <= fbrt_pkg::RC_OK;
                  state_r    <= S_WR_NEW;
                end else begin
                  state_r <= S_MUL;
                end
              end
              default: state_r <= S_MUL;
            endcase
          end
        end

        S_SCAN: begin
          // issue one read per cycle
          if (scan_r < n_r) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= scan_r;
            scan_r   <= scan_r + CNT_W'(1);
          end else begin
            rd_vld_r <= 1'b0;
          end
          // check the entry read last cycle, keeping the lowest hits
          if (rd_vld_r) begin
            if (!hit_f_r && rd_data_r.st == fbrt_pkg::ST_VALID &&
                rd_data_r.lg == req_r.logical_index) begin
              hit_f_r <= 1'b1;
              hit_r   <= rd_idx_r[IDX_W-1:0];
            end
            if (!free_f_r && rd_data_r.st == fbrt_pkg::ST_FREE) begin
              free_f_r <= 1'b1;
              free_r   <= rd_idx_r[IDX_W-1:0];
            end
            if (rd_idx_r == n_r - CNT_W'(1)) begin
              rd_vld_r <= 1'b0;
              state_r  <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          if (req_r.action == fbrt_pkg::ACT_LOOKUP) begin
            status_r <= hit_f_r ? fbrt_pkg::RC_OK : fbrt_pkg::RC_UNMAPPED;
            idx_r    <= hit_r;
            state_r  <= S_MUL;
          end else if (free_f_r) begin
            status_r   <= fbrt_pkg::RC_OK;
            idx_r      <= free_r;
            wdata_r.st <= fbrt_pkg::ST_VALID;
            wdata_r.lg <= req_r.logical_index;
            retired_r  <= hit_f_r;
            state_r    <= hit_f_r ? S_WR_OLD : S_WR_NEW;
          end else begin
            status_r <= fbrt_pkg::RC_FULL;
            state_r  <= S_MUL;
          end
        end

        S_WR_OLD: state_r <= S_WR_NEW;

        S_WR_NEW: state_r <= S_MUL;

        S_MUL: begin
          prod_r  <= fbrt_pkg::ADDR_W'(idx_r) * fbrt_pkg::ADDR_W'(BLOCK_BYTES);
          state_r <= S_OUT;
        end

        S_OUT: begin
          out_valid_r <= 1'b1;
          out_rsp_r.status <= status_r;
          if (status_r == fbrt_pkg::RC_OK) begin
            out_rsp_r.physical_index   <= fbrt_pkg::PHYS_W'(idx_r);
            out_rsp_r.physical_address <= prod_r + base_r;
            out_rsp_r.old_retired      <= retired_r;
          end else begin
            out_rsp_r.physical_index   <= '0;
            out_rsp_r.physical_address <= '0;
            out_rsp_r.old_retired      <= 1'b0;
          end
          state_r <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

  // action code that the block does not define, must be rejected
  localparam logic [fbrt_pkg::ACTION_W-1:0] ACT_UNDEFINED = 2'd3;
  // longest quiet stretch: clearing pass plus a full table scan, several times over
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk;
  logic rst_n = 1'b0;

  // request channel
  logic start = 1'b0;
  logic busy;
  fbrt_pkg::req_t in_req = '0;
  // response channel
  logic out_valid;
  fbrt_pkg::rsp_t out_rsp;
  // configuration channel
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fbrt_pkg::CFG_IDX_W-1:0]  cfg_index = fbrt_pkg::REG_BLOCKS_IN_USE;
  logic [fbrt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the remap table and its registers
  logic [fbrt_pkg::STATE_W-1:0]   tbl_state   [fbrt_pkg::TABLE_ENTRIES_DEF];
  logic [fbrt_pkg::LOGICAL_W-1:0] tbl_logical [fbrt_pkg::TABLE_ENTRIES_DEF];
  logic [fbrt_pkg::BLOCKS_W-1:0]  blocks_cfg;
  logic [fbrt_pkg::ADDR_W-1:0]    base_cfg;

  // responses still owed by the block, oldest first
  fbrt_pkg::rsp_t mapping_rsp_q[$];

  int req_count   = 0;
  int rsp_count   = 0;
  int cfg_count   = 0;
  int error_count = 0;
  int quiet_count = 0;

  flash_block_remap_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // table shadow
  // ---------------------------------------------------------------------------

  // block count register clamps to the table size
  function automatic int managed_blocks();
    return (blocks_cfg > fbrt_pkg::TABLE_ENTRIES_DEF) ? fbrt_pkg::TABLE_ENTRIES_DEF
                                                      : int'(blocks_cfg);
  endfunction

  // lowest valid entry below n mapping lg, n when there is none
  function automatic int find_mapping(logic [fbrt_pkg::LOGICAL_W-1:0] lg, int n);
    for (int i = 0; i < n; i++)
      if (tbl_state[i] == fbrt_pkg::ST_VALID && tbl_logical[i] == lg) return i;
    return n;
  endfunction

  // updates the shadow table and returns the response the block owes
  function automatic fbrt_pkg::rsp_t apply_table_request(fbrt_pkg::req_t r);
    fbrt_pkg::rsp_t rsp;
    int   n;
    int   hit;
    int   fr;
    n = managed_blocks();
    rsp = '0;
    rsp.status = fbrt_pkg::RC_RANGE;
    case (r.action)
      fbrt_pkg::ACT_LOOKUP: begin
        if (r.logical_index < n) begin
          hit = find_mapping(r.logical_index, n);
          if (hit < n) begin
            rsp.status = fbrt_pkg::RC_OK;
            rsp.physical_index = hit[fbrt_pkg::PHYS_W-1:0];
          end else begin
            rsp.status = fbrt_pkg::RC_UNMAPPED;
          end
        end
      end
      fbrt_pkg::ACT_WRITE: begin
        if (r.logical_index < n) begin
          for (fr = 0; fr < n; fr++)
            if (tbl_state[fr] == fbrt_pkg::ST_FREE) break;
          if (fr < n) begin
            // the old mapping is looked up before the new one exists
            hit = find_mapping(r.logical_index, n);
            if (hit < n) begin
              tbl_state[hit] = fbrt_pkg::ST_DIRTY;
              rsp.old_retired = 1'b1;
            end
            tbl_state[fr] = fbrt_pkg::ST_VALID;
            tbl_logical[fr] = r.logical_index;
            rsp.status = fbrt_pkg::RC_OK;
            rsp.physical_index = fr[fbrt_pkg::PHYS_W-1:0];
          end else begin
            rsp.status = fbrt_pkg::RC_FULL;
          end
        end
      end
      fbrt_pkg::ACT_RESTORE: begin
        // a free entry may carry any logical index, it is dropped anyway
        if (r.entry_index < n &&
            (r.entry_state == fbrt_pkg::ST_FREE || r.logical_index < n)) begin
          tbl_state[r.entry_index] = r.entry_state;
          tbl_logical[r.entry_index] = (r.entry_state == fbrt_pkg::ST_FREE)
                                       ? '0 : r.logical_index;
          rsp.status = fbrt_pkg::RC_OK;
          rsp.physical_index = r.entry_index;
        end
      end
      default: ;
    endcase
    if (rsp.status == fbrt_pkg::RC_OK)
      rsp.physical_address = 32'(int'(rsp.physical_index) * fbrt_pkg::BLOCK_BYTES_DEF)
                             + base_cfg;
    return rsp;
  endfunction

  function automatic fbrt_pkg::req_t mk_req(logic [fbrt_pkg::ACTION_W-1:0] act, int lg,
                                            int ent, logic [fbrt_pkg::STATE_W-1:0] st);
    fbrt_pkg::req_t r;
    r.action = act;
    r.logical_index = lg[fbrt_pkg::LOGICAL_W-1:0];
    r.entry_index = ent[fbrt_pkg::ENTRY_W-1:0];
    r.entry_state = st;
    return r;
  endfunction

  // mostly well-formed traffic inside the managed range, some pure noise
  function automatic fbrt_pkg::req_t random_table_req();
    fbrt_pkg::req_t r;
    int   n;
    int   pick;
    n = managed_blocks();
    r.action = fbrt_pkg::ACTION_W'($urandom);
    r.logical_index = fbrt_pkg::LOGICAL_W'($urandom);
    r.entry_index = fbrt_pkg::ENTRY_W'($urandom);
    r.entry_state = fbrt_pkg::STATE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (n > 0 && pick < 90) begin
      r.logical_index = fbrt_pkg::LOGICAL_W'($urandom_range(0, n - 1));
      r.entry_index = fbrt_pkg::ENTRY_W'($urandom_range(0, n - 1));
      if (pick < 40) begin
        r.action = fbrt_pkg::ACT_WRITE;
      end else if (pick < 72) begin
        r.action = fbrt_pkg::ACT_LOOKUP;
      end else begin
        // lean toward freeing entries so the table keeps turning over
        r.action = fbrt_pkg::ACT_RESTORE;
        if ($urandom_range(0, 1)) r.entry_state = fbrt_pkg::ST_FREE;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // start stays high on return so back-to-back requests need no extra edge
  task automatic send_req(input fbrt_pkg::req_t r);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    mapping_rsp_q.push_back(apply_table_request(r));
    req_count++;
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender waits until every owed response is back and the block is idle
  task automatic drain_requests();
    start <= 1'b0;
    do @(posedge clk); while (mapping_rsp_q.size() != 0 || busy !== 1'b0);
  endtask

  // both registers, back to back, valid held across the pair
  task automatic set_table_config(input logic [fbrt_pkg::CFG_DATA_W-1:0] count_word,
                                  input logic [fbrt_pkg::CFG_DATA_W-1:0] base);
    for (int k = 0; k < 2; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (k == 0) ? fbrt_pkg::REG_BLOCKS_IN_USE : fbrt_pkg::REG_FLASH_BASE;
      cfg_data <= (k == 0) ? count_word : base;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      if (k == 0) blocks_cfg = count_word[fbrt_pkg::BLOCKS_W-1:0];
      else base_cfg = base;
      cfg_count++;
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: 3968 blocks, base zero, whole table free
  task automatic test_reset_defaults();
    send_req(mk_req(fbrt_pkg::ACT_LOOKUP, 0, 0, fbrt_pkg::ST_FREE));     // nothing mapped yet
    send_req(mk_req(fbrt_pkg::ACT_WRITE, 3967, 0, fbrt_pkg::ST_FREE));   // top index in range
    send_req(mk_req(fbrt_pkg::ACT_WRITE, 3968, 0, fbrt_pkg::ST_FREE));   // first out of range
    send_req(mk_req(fbrt_pkg::ACT_LOOKUP, 3967, 0, fbrt_pkg::ST_FREE));
    send_req(mk_req(ACT_UNDEFINED, 5, 5, fbrt_pkg::ST_VALID));           // undefined action
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 1, 3968, fbrt_pkg::ST_VALID)); // entry past count
    drain_requests();
  endtask

  // full table, clamped count, wrapping address, zero and one block
  task automatic test_count_extremes();
    set_table_config(32'd4096, 32'hFFFF_FF00);
    send_req(mk_req(fbrt_pkg::ACT_WRITE, 4095, 0, fbrt_pkg::ST_FREE));   // address wraps
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 4095, 4095, fbrt_pkg::ST_VALID));
    drain_requests();
    // every data bit set: count clamps to the table size
    set_table_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(mk_req(fbrt_pkg::ACT_LOOKUP, 4095, 0, fbrt_pkg::ST_FREE));  // lowest of two
    drain_requests();
    set_table_config(32'd0, 32'h0000_0000);
    send_req(mk_req(fbrt_pkg::ACT_LOOKUP, 0, 0, fbrt_pkg::ST_FREE));
    send_req(mk_req(fbrt_pkg::ACT_WRITE, 0, 0, fbrt_pkg::ST_FREE));
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 0, 0, fbrt_pkg::ST_FREE));
    drain_requests();
    set_table_config(32'd1, 32'h0000_0000);
    send_req(mk_req(fbrt_pkg::ACT_WRITE, 0, 0, fbrt_pkg::ST_FREE));      // only entry taken
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 4095, 0, fbrt_pkg::ST_FREE)); // index dropped
    send_req(mk_req(fbrt_pkg::ACT_WRITE, 0, 0, fbrt_pkg::ST_FREE));
    drain_requests();
  endtask

  // duplicate mappings, unused and dirty entries, full table at a small count
  task automatic test_table_cases();
    set_table_config(32'd6, 32'h1000_0000);
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 3, 2, fbrt_pkg::ST_VALID));
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 3, 4, fbrt_pkg::ST_VALID));  // second mapping
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 5, 3, fbrt_pkg::ST_UNUSED)); // not valid, not free
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 1, 5, fbrt_pkg::ST_DIRTY));
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 6, 1, fbrt_pkg::ST_VALID));  // index past count
    send_req(mk_req(fbrt_pkg::ACT_LOOKUP, 3, 0, fbrt_pkg::ST_FREE));    // lowest mapping wins
    send_req(mk_req(fbrt_pkg::ACT_WRITE, 3, 0, fbrt_pkg::ST_FREE));     // unused skipped: full
    send_req(mk_req(fbrt_pkg::ACT_RESTORE, 9, 1, fbrt_pkg::ST_FREE));
    send_req(mk_req(fbrt_pkg::ACT_WRITE, 3, 0, fbrt_pkg::ST_FREE));     // retires the lowest
    send_req(mk_req(fbrt_pkg::ACT_LOOKUP, 3, 0, fbrt_pkg::ST_FREE));
    drain_requests();
  endtask

  // random traffic in phases, each with its own block count and base
  task automatic test_random_traffic();
    int phase_count [8] = '{8, 3, 16, 1, 200, 5, 4500, 12};
    int phase_items [8] = '{20, 16, 20, 10, 16, 18, 5, 10};
    logic [fbrt_pkg::CFG_DATA_W-1:0] count_word;
    for (int p = 0; p < 8; p++) begin
      // unused upper bits of the count register get random values
      count_word = $urandom;
      count_word[fbrt_pkg::BLOCKS_W-1:0] = fbrt_pkg::BLOCKS_W'(phase_count[p]);
      set_table_config(count_word, $urandom);
      for (int k = 0; k < phase_items[p]; k++) begin
        // no idle bursts in the last two phases
        if (p < 6 && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
        // mid-phase stop: everything outstanding must come back first
        if (p == 2 && k == phase_items[p] / 2) drain_requests();
        send_req(random_table_req());
      end
      drain_requests();
    end
  endtask

  // ---------------------------------------------------------------------------
  // response checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : rsp_check
    fbrt_pkg::rsp_t want;
    if (rst_n && out_valid) begin
      rsp_count++;
      if (mapping_rsp_q.size() == 0) begin
        $error("response with no request outstanding: %p", out_rsp);
        error_count++;
      end else begin
        want = mapping_rsp_q.pop_front();
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp.status);
          error_count++;
        end
        if (out_rsp.physical_index !== want.physical_index) begin
          $error("physical_index: expected %0d, actual %0d",
                 want.physical_index, out_rsp.physical_index);
          error_count++;
        end
        if (out_rsp.physical_address !== want.physical_address) begin
          $error("physical_address: expected 0x%08h, actual 0x%08h",
                 want.physical_address, out_rsp.physical_address);
          error_count++;
        end
        if (out_rsp.old_retired !== want.old_retired) begin
          $error("old_retired: expected %0d, actual %0d",
                 want.old_retired, out_rsp.old_retired);
          error_count++;
        end
      end
    end
  end

  // watchdog: any accepted request, response or register write counts as progress
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    int directed_reqs;
    // shadow starts as the block does after its clearing pass
    for (int i = 0; i < fbrt_pkg::TABLE_ENTRIES_DEF; i++) begin
      tbl_state[i] = fbrt_pkg::ST_FREE;
      tbl_logical[i] = '0;
    end
    blocks_cfg = fbrt_pkg::RESET_BLOCKS;
    base_cfg = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_count_extremes();
    test_table_cases();
    directed_reqs = req_count;
    test_random_traffic();

    drain_requests();
    // room for a stray response after the last one owed
    repeat (managed_blocks() + 16) @(posedge clk);

    $display("covered %0d requests (%0d directed, %0d random), %0d register writes",
             req_count, directed_reqs, req_count - directed_reqs, cfg_count);
    $display("checked %0d responses, %0d mismatches, %0d still owed",
             rsp_count, error_count, mapping_rsp_q.size());
    if (error_count == 0 && mapping_rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/fbrt_pkg.sv
hdl/flash_block_remap_table.sv
dv/tb_top.sv
